// File: rtl/kwm_pkg.sv
`timescale 1ns / 1ps

package kwm_pkg;

    // Default sizing of the queue set
    localparam int LISTS_DEF = 8;
    localparam int DEPTH_DEF = 64;

    // Fixed field widths
    localparam int FUNC_W     = 2;
    localparam int LIST_IDX_W = 3;
    localparam int VALUE_W    = 32;

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 1;

    // Operation codes carried on the input tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_PUSH_RD = 6'b000010,
        S_PUSH_WR = 6'b000100,
        S_SCAN    = 6'b001000,
        S_POP_WB  = 6'b010000,
        S_RESP    = 6'b100000
    } t_state;

endpackage

// File: rtl/kwm_ram.sv
`timescale 1ns / 1ps

module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/k_way_sorted_merge.sv
`timescale 1ns / 1ps
// Steps: a clear or no-op goes straight to the response; a push reads the queue's metadata
// and then writes it; a pop scans every queue and then writes back; the result is then
// loaded into the output register. Throughput: one operation at a time; a pop is set
// by the head scan, one queue per cycle through the metadata memory and then the element memory.
// Reset (synchronous, active low) empties every queue and the output register at once;
// the element memory keeps its contents, and no value read from it is used before being written.
module k_way_sorted_merge #(
    parameter int LISTS = kwm_pkg::LISTS_DEF,
    parameter int DEPTH = kwm_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] list_index, [34:3] value, [39:35] zero
    input  logic [kwm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [kwm_pkg::FUNC_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] result_value, [34:32] source_list, [35] all_empty, [36] push_rejected,
    // [39:37] zero
    output logic [kwm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] result_valid
    output logic [kwm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

    localparam int VW    = kwm_pkg::VALUE_W;
    localparam int IW    = kwm_pkg::LIST_IDX_W;
    localparam int QW    = $clog2(LISTS);
    localparam int CW    = QW + 1;
    localparam int SLOTS = 1 << QW;
    localparam int RPW   = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int MW    = VW + FW + RPW;
    localparam int AW    = $clog2(LISTS * DEPTH);

    // Base of a queue's region in the element memory plus an offset
    function automatic logic [AW-1:0] elem_addr(input logic [QW-1:0] q,
                                                input logic [RPW-1:0] off);
        logic [AW-1:0] base;
        base = AW'(AW'(q) * AW'(DEPTH));
        return base + AW'(off);
    endfunction

    kwm_pkg::t_state r_state, n_state;

    // Latched operation
    kwm_pkg::t_func        r_func;
    logic [IW-1:0]         r_qi;
    logic signed [VW-1:0]  r_val;

    // Per-queue flags: metadata entry written since clear, queue holds elements
    logic [SLOTS-1:0] r_meta_valid;
    logic [SLOTS-1:0] r_nonempty;

    // Scan pipeline
    logic [CW-1:0]        r_scan_idx;
    logic                 r_p1_valid, r_p1_live;
    logic [QW-1:0]        r_p1_q;
    logic                 r_p2_valid, r_p2_live;
    logic [QW-1:0]        r_p2_q;
    logic [RPW-1:0]       r_p2_rp;
    logic [FW-1:0]        r_p2_fill;
    logic signed [VW-1:0] r_p2_tail;
    logic                 r_found;
    logic [QW-1:0]        r_best_q;
    logic signed [VW-1:0] r_best_v;
    logic [RPW-1:0]       r_best_rp;
    logic [FW-1:0]        r_best_fill;
    logic signed [VW-1:0] r_best_tail;

    // Pending result and output register
    logic                 r_res_valid, r_res_rej;
    logic signed [VW-1:0] r_res_value;
    logic [IW-1:0]        r_res_src;
    logic                 r_out_valid;
    logic [kwm_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [kwm_pkg::OUT_TUSER_W-1:0] r_out_user;

    // Memory ports
    logic            meta_we;
    logic [QW-1:0]   meta_waddr, meta_raddr;
    logic [MW-1:0]   meta_wdata, meta_rdata;
    logic            el_we;
    logic [AW-1:0]   el_waddr, el_raddr;
    logic [VW-1:0]   el_wdata, el_rdata;

    logic in_xfer, out_load, scan_issue, scan_done;
    logic [RPW-1:0]       md_rp;
    logic [FW-1:0]        md_fill;
    logic signed [VW-1:0] md_tail;

    // Push evaluation
    logic [QW-1:0]        push_q;
    logic                 push_in_range, pm_valid, push_rej;
    logic [RPW-1:0]       p_rp, push_slot;
    logic [FW-1:0]        p_fill;
    logic signed [VW-1:0] p_tail;
    logic [RPW:0]         slot_sum;

    // Pop write-back values
    logic [RPW-1:0] pop_rp;
    logic [FW-1:0]  pop_fill;

    logic head_better;

    kwm_ram #(.WIDTH(MW), .DEPTH(LISTS)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    kwm_ram #(.WIDTH(VW), .DEPTH(LISTS * DEPTH)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (el_we),
        .i_waddr (el_waddr),
        .i_wdata (el_wdata),
        .i_raddr (el_raddr),
        .o_rdata (el_rdata)
    );

    assign s_axis_tready = (r_state == kwm_pkg::S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == kwm_pkg::S_RESP) && (!r_out_valid || m_axis_tready);

    assign md_rp   = meta_rdata[RPW-1:0];
    assign md_fill = meta_rdata[RPW +: FW];
    assign md_tail = meta_rdata[RPW+FW +: VW];

    // Scan control: issue one queue per cycle, finish when the pipe drains
    assign scan_issue = (r_state == kwm_pkg::S_SCAN) && (r_scan_idx < CW'(LISTS));
    assign scan_done  = (r_state == kwm_pkg::S_SCAN) && (r_scan_idx == CW'(LISTS))
                        && !r_p1_valid && !r_p2_valid;
    assign head_better = r_p2_valid && r_p2_live
                         && (!r_found || ($signed(el_rdata) < r_best_v));

    // Push check against the queue's metadata; an unwritten entry reads as empty
    always_comb begin
        push_q        = QW'(r_qi);
        push_in_range = 32'(r_qi) < 32'(LISTS);
        pm_valid      = push_in_range && r_meta_valid[push_q];
        p_rp          = pm_valid ? md_rp : '0;
        p_fill        = pm_valid ? md_fill : '0;
        p_tail        = pm_valid ? md_tail : '0;
        push_rej      = !push_in_range || (p_fill >= FW'(DEPTH))
                        || ((p_fill != '0) && (r_val < p_tail));
        slot_sum      = (RPW+1)'(p_rp) + (RPW+1)'(p_fill);
        push_slot     = (slot_sum >= (RPW+1)'(DEPTH)) ? RPW'(slot_sum - (RPW+1)'(DEPTH))
                                                      : RPW'(slot_sum);
    end

    // Advance the chosen queue's read position on a pop
    always_comb begin
        pop_rp   = (r_best_rp == RPW'(DEPTH - 1)) ? '0 : r_best_rp + RPW'(1);
        pop_fill = r_best_fill - FW'(1);
    end

    // Memory port steering
    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = push_q;
        meta_wdata = {r_val, p_fill + FW'(1), p_rp};
        meta_raddr = r_scan_idx[QW-1:0];
        el_we      = 1'b0;
        el_waddr   = elem_addr(push_q, push_slot);
        el_wdata   = r_val;
        el_raddr   = elem_addr(r_p1_q, md_rp);
        unique case (r_state)
            kwm_pkg::S_PUSH_RD: begin
                meta_raddr = push_q;
            end
            kwm_pkg::S_PUSH_WR: begin
                meta_we = !push_rej;
                el_we   = !push_rej;
            end
            kwm_pkg::S_POP_WB: begin
                meta_we    = r_found;
                meta_waddr = r_best_q;
                meta_wdata = {r_best_tail, pop_fill, pop_rp};
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kwm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    unique case (kwm_pkg::t_func'(s_axis_tuser))
                        kwm_pkg::FUNC_PUSH:  n_state = kwm_pkg::S_PUSH_RD;
                        kwm_pkg::FUNC_POP:   n_state = kwm_pkg::S_SCAN;
                        kwm_pkg::FUNC_CLEAR: n_state = kwm_pkg::S_RESP;
                        kwm_pkg::FUNC_NOP:   n_state = kwm_pkg::S_RESP;
                        default:             n_state = kwm_pkg::S_RESP;
                    endcase
                end
            end
            kwm_pkg::S_PUSH_RD: n_state = kwm_pkg::S_PUSH_WR;
            kwm_pkg::S_PUSH_WR: n_state = kwm_pkg::S_RESP;
            kwm_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = kwm_pkg::S_POP_WB;
                end
            end
            kwm_pkg::S_POP_WB: n_state = kwm_pkg::S_RESP;
            kwm_pkg::S_RESP: begin
                if (out_load) begin
                    n_state = kwm_pkg::S_IDLE;
                end
            end
            default: n_state = kwm_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= kwm_pkg::S_IDLE;
            r_meta_valid <= '0;
            r_nonempty   <= '0;
            r_p1_valid   <= 1'b0;
            r_p2_valid   <= 1'b0;
            r_found      <= 1'b0;
            r_scan_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // Clear drops every queue at once
            if (in_xfer && (kwm_pkg::t_func'(s_axis_tuser) == kwm_pkg::FUNC_CLEAR)) begin
                r_meta_valid <= '0;
                r_nonempty   <= '0;
            end

            // Restart the scan index and best flag on every input transfer
            if (in_xfer) begin
                r_scan_idx <= '0;
                r_found    <= 1'b0;
            end

            // Scan pipeline valids
            r_p1_valid <= scan_issue;
            r_p2_valid <= r_p1_valid;
            if (scan_issue) begin
                r_scan_idx <= r_scan_idx + CW'(1);
            end
            if (head_better) begin
                r_found <= 1'b1;
            end

            // Accepted push marks the queue written and non-empty
            if ((r_state == kwm_pkg::S_PUSH_WR) && !push_rej) begin
                r_meta_valid[push_q] <= 1'b1;
                r_nonempty[push_q]   <= 1'b1;
            end

            // Pop empties the queue when its last element leaves
            if ((r_state == kwm_pkg::S_POP_WB) && r_found) begin
                r_nonempty[r_best_q] <= (r_best_fill != FW'(1));
            end

            // Output register handshake
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // Latch the operation and default the result
        if (in_xfer) begin
            r_func      <= kwm_pkg::t_func'(s_axis_tuser);
            r_qi        <= s_axis_tdata[IW-1:0];
            r_val       <= s_axis_tdata[IW +: VW];
            r_res_valid <= 1'b0;
            r_res_value <= '0;
            r_res_src   <= '0;
            r_res_rej   <= 1'b0;
        end

        // Stage 1: queue index waits for its metadata
        r_p1_q    <= r_scan_idx[QW-1:0];
        r_p1_live <= r_nonempty[r_scan_idx[QW-1:0]];

        // Stage 2: metadata waits for the head element
        r_p2_q    <= r_p1_q;
        r_p2_live <= r_p1_live;
        r_p2_rp   <= md_rp;
        r_p2_fill <= md_fill;
        r_p2_tail <= md_tail;

        // Stage 3: keep the smallest head, lowest queue on ties
        if (head_better) begin
            r_best_q    <= r_p2_q;
            r_best_v    <= $signed(el_rdata);
            r_best_rp   <= r_p2_rp;
            r_best_fill <= r_p2_fill;
            r_best_tail <= r_p2_tail;
        end

        if ((r_state == kwm_pkg::S_PUSH_WR) && (r_func == kwm_pkg::FUNC_PUSH)) begin
            r_res_rej <= push_rej;
        end

        if ((r_state == kwm_pkg::S_POP_WB) && r_found) begin
            r_res_valid <= 1'b1;
            r_res_value <= r_best_v;
            r_res_src   <= IW'(r_best_q);
        end

        // Load the output register
        if (out_load) begin
            r_out_data <= {3'b000, r_res_rej, ~|r_nonempty, r_res_src, r_res_value};
            r_out_user <= r_res_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
